/* rtl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache tag model.
// Used by the controller, the datapath and the top level; depends on nothing.
package salc_pkg;

    localparam int ADDR_WIDTH = 32;
    localparam int OFFSET_MIN = 3;
    localparam int OFFSET_MAX = 12;
    localparam int TAG_W      = ADDR_WIDTH - OFFSET_MIN;
    localparam int SET_OUT_W  = 8;
    localparam int WAYS_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE   = 2'd3;

    // Configuration reset values.
    localparam logic       RST_WRITE_THROUGH = 1'b0;
    localparam logic [3:0] RST_OFFSET_BITS   = 4'd5;
    localparam logic [3:0] RST_INDEX_BITS    = 4'd4;
    localparam logic [3:0] RST_WAYS_IN_USE   = 4'd2;

    // Access kinds.
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic [ADDR_WIDTH-1:0] address;
    } req_t;

    typedef struct packed {
        logic                  hit;
        logic                  writeback;
        logic [ADDR_WIDTH-1:0] writeback_address;
        logic [SET_OUT_W-1:0]  set_index;
        logic [TAG_W-1:0]      tag_out;
    } rsp_t;

    // Clamped geometry and write policy in effect for one item.
    typedef struct packed {
        logic              write_through;
        logic [3:0]        offset_bits;
        logic [3:0]        index_bits;
        logic [WAYS_W-1:0] ways;
    } geom_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic look;
        logic update;
    } ctl_cmd_t;

endpackage

/* rtl/salc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds one cache set per row in this design.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/salc_ctrl.sv */
// Sequencer for the cache: accept, lookup and update steps, plus the result strobe.
// Depends on salc_pkg for the command struct.
module salc_ctrl import salc_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output ctl_cmd_t ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;

    // The update step does not block a new item; the datapath forwards the
    // row being written when the new item lands in the same set.
    assign busy       = (state_reg == S_LOOK);
    assign ctl.load   = start && !busy;
    assign ctl.look   = (state_reg == S_LOOK);
    assign ctl.update = (state_reg == S_UPD);
    assign done       = done_reg;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_LOOK : S_IDLE;
            S_LOOK:  state_next = S_UPD;
            S_UPD:   state_next = start ? S_LOOK : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ctl.update;
        end
    end

    a_look_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOOK) |=> (state_reg == S_UPD))
        else $error("lookup step not followed by update step");

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> ##1 ctl.update ##1 done)
        else $error("accepted item did not produce a result strobe");

endmodule

/* rtl/salc_dpath.sv */
// Datapath of the cache: address split, set RAM, hit and victim search, LRU update.
// Depends on salc_pkg and instantiates salc_ram.
module salc_dpath import salc_pkg::*; #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    input  ctl_cmd_t ctl,
    input  req_t     request,
    input  geom_t    geom,
    output rsp_t     result
);

    localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int ENT_W  = TAG_W + 2 + RANK_W;
    localparam int ROW_W  = MAX_WAYS * ENT_W;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              valid;
        logic              dirty;
        logic [RANK_W-1:0] rank;
    } entry_t;

    // Load step.
    logic [ADDR_WIDTH-1:0] a_shift;
    logic [SET_OUT_W-1:0]  set_mask;
    logic [SET_OUT_W-1:0]  set_new;
    logic [4:0]            cut_new;
    logic [TAG_W-1:0]      tag_new;

    logic                  cmd_reg;
    logic [SET_OUT_W-1:0]  set_reg;
    logic [TAG_W-1:0]      tag_reg;
    geom_t                 geom_reg;
    logic                  rv_reg;
    logic                  fwd_reg;
    logic [MAX_SETS-1:0]   row_valid_reg;

    // Lookup step.
    logic [ROW_W-1:0]                ram_rdata;
    entry_t [MAX_WAYS-1:0]           ram_row;
    entry_t [MAX_WAYS-1:0]           cur_row;
    logic [MAX_WAYS-1:0]             in_use;
    logic [MAX_WAYS-1:0]             hit_vec;
    logic [MAX_WAYS-1:0]             free_vec;
    logic [MAX_WAYS-1:0]             lru_vec;
    logic [WAY_W-1:0]                hit_idx;
    logic [WAY_W-1:0]                free_idx;
    logic [WAY_W-1:0]                lru_idx;
    logic [WAY_W-1:0]                tgt_idx;
    logic                            any_hit;
    logic                            alloc;

    entry_t [MAX_WAYS-1:0]           row_reg;
    logic                            hit_reg;
    logic                            alloc_reg;
    logic [WAY_W-1:0]                tgt_reg;

    // Update step.
    entry_t [MAX_WAYS-1:0]           new_row;
    entry_t [MAX_WAYS-1:0]           last_row_reg;
    entry_t                          tgt_ent;
    logic [WAYS_W-1:0]               r_lim;
    logic [4:0]                      cut_reg;
    logic                            wb;
    logic [ADDR_WIDTH-1:0]           wb_addr;
    rsp_t                            result_reg;

    // Split the address with the geometry in effect.
    always_comb
    begin
        a_shift  = request.address >> geom.offset_bits;
        set_mask = SET_OUT_W'((9'd1 << geom.index_bits) - 9'd1);
        set_new  = a_shift[SET_OUT_W-1:0] & set_mask;
        cut_new  = {1'b0, geom.offset_bits} + {1'b0, geom.index_bits};
        tag_new  = TAG_W'(request.address >> cut_new);
    end

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_ram (
        .clk   (clk),
        .we    (ctl.update),
        .waddr (set_reg[SET_W-1:0]),
        .wdata (new_row),
        .re    (ctl.load),
        .raddr (set_new[SET_W-1:0]),
        .rdata (ram_rdata)
    );

    assign ram_row = ram_rdata;

    // A set never written reads as all lines invalid with rank zero. The row
    // written in the same cycle as the load is taken from the bypass register.
    always_comb
    begin
        if (fwd_reg)
        begin
            cur_row = last_row_reg;
        end
        else if (rv_reg)
        begin
            cur_row = ram_row;
        end
        else
        begin
            cur_row = '0;
        end
    end

    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w]   = (WAYS_W'(w) < geom_reg.ways);
            hit_vec[w]  = in_use[w] && cur_row[w].valid && (cur_row[w].tag == tag_reg);
            free_vec[w] = in_use[w] && !cur_row[w].valid;
        end
    end

    // Oldest way: highest rank, lowest way on a tie.
    always_comb
    begin
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            lru_vec[w] = in_use[w];
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if (v < w && in_use[v] && (cur_row[v].rank >= cur_row[w].rank))
                begin
                    lru_vec[w] = 1'b0;
                end
                if (v > w && in_use[v] && (cur_row[v].rank > cur_row[w].rank))
                begin
                    lru_vec[w] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_idx = WAY_W'(w);
            end
            if (free_vec[w])
            begin
                free_idx = WAY_W'(w);
            end
            if (lru_vec[w])
            begin
                lru_idx = WAY_W'(w);
            end
        end
        any_hit = |hit_vec;
        if (any_hit)
        begin
            tgt_idx = hit_idx;
        end
        else if (|free_vec)
        begin
            tgt_idx = free_idx;
        end
        else
        begin
            tgt_idx = lru_idx;
        end
        alloc = !any_hit && ((cmd_reg == CMD_READ) || !geom_reg.write_through);
    end

    // LRU update: lines more recent than the target age by one, saturating
    // at the way count less one. An invalid target counts as oldest of all.
    always_comb
    begin
        tgt_ent = row_reg[tgt_reg];
        r_lim   = tgt_ent.valid ? WAYS_W'(tgt_ent.rank) : geom_reg.ways;
        new_row = row_reg;
        if (hit_reg || alloc_reg)
        begin
            for (int v = 0; v < MAX_WAYS; v++)
            begin
                if ((WAY_W'(v) != tgt_reg) && in_use[v] && row_reg[v].valid
                    && (WAYS_W'(row_reg[v].rank) < r_lim)
                    && ((WAYS_W'(row_reg[v].rank) + WAYS_W'(1)) < geom_reg.ways))
                begin
                    new_row[v].rank = row_reg[v].rank + RANK_W'(1);
                end
            end
            new_row[tgt_reg].rank = '0;
        end
        if (hit_reg && (cmd_reg == CMD_WRITE) && !geom_reg.write_through)
        begin
            new_row[tgt_reg].dirty = 1'b1;
        end
        if (alloc_reg)
        begin
            new_row[tgt_reg].tag   = tag_reg;
            new_row[tgt_reg].valid = 1'b1;
            new_row[tgt_reg].dirty = (cmd_reg == CMD_WRITE);
        end
        cut_reg = {1'b0, geom_reg.offset_bits} + {1'b0, geom_reg.index_bits};
        wb      = alloc_reg && tgt_ent.valid && tgt_ent.dirty;
        wb_addr = (ADDR_WIDTH'(tgt_ent.tag) << cut_reg)
                | (ADDR_WIDTH'(set_reg) << geom_reg.offset_bits);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ctl.update)
        begin
            row_valid_reg[set_reg[SET_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= request.cmd;
            set_reg  <= set_new;
            tag_reg  <= tag_new;
            geom_reg <= geom;
            rv_reg   <= row_valid_reg[set_new[SET_W-1:0]];
            fwd_reg  <= ctl.update && (set_new == set_reg);
        end
        if (ctl.look)
        begin
            row_reg   <= cur_row;
            hit_reg   <= any_hit;
            alloc_reg <= alloc;
            tgt_reg   <= tgt_idx;
        end
        if (ctl.update)
        begin
            last_row_reg                 <= new_row;
            result_reg.hit               <= hit_reg;
            result_reg.writeback         <= wb;
            result_reg.writeback_address <= wb ? wb_addr : '0;
            result_reg.set_index         <= set_reg;
            result_reg.tag_out           <= tag_reg;
        end
    end

    assign result = result_reg;

    a_wb_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> (!result.writeback || !result.hit))
        else $error("write-back reported on a hit");

    a_wb_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> (result.writeback || (result.writeback_address == '0)))
        else $error("write-back address set without a write-back");

    a_set_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> row_valid_reg[$past(set_reg[SET_W-1:0])])
        else $error("updated set not marked as written");

endmodule

/* rtl/set_assoc_lru_data_cache.sv */
// Set-associative data cache tag model with true LRU, write-back or write-through.
// Each item passes through the load, lookup and update steps; the result strobe is registered after the update.
// Items overlap: a new one may be accepted during the update step of the last, not during its lookup,
// set by the registered read of the set RAM followed by the lookup and the update of the same row.
// Reset: asynchronous, clears control state, configuration and the per-set marks;
// the receiver cannot stall, so a result is shown for exactly one cycle.
module set_assoc_lru_data_cache import salc_pkg::*; #(
    parameter int MAX_SETS = 256,
    parameter int MAX_WAYS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  req_t                  request,
    output logic                  done,
    output rsp_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Largest index bit count whose set count fits in MAX_SETS, capped at
    // the width of the set index field.
    localparam int IDX_FLOOR = $clog2(MAX_SETS + 1) - 1;
    localparam int IDX_MAX   = (IDX_FLOOR > SET_OUT_W) ? SET_OUT_W : IDX_FLOOR;

    logic       write_through_reg;
    logic [3:0] offset_bits_reg;
    logic [3:0] index_bits_reg;
    logic [3:0] ways_in_use_reg;

    geom_t      geom;
    ctl_cmd_t   ctl;

    // Configuration writes land directly; the user must issue them only while the
    // block holds no item, as the block does not enforce it; the datapath samples
    // the geometry when an item is accepted. Each stored line is kept across geometry changes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_through_reg <= RST_WRITE_THROUGH;
            offset_bits_reg   <= RST_OFFSET_BITS;
            index_bits_reg    <= RST_INDEX_BITS;
            ways_in_use_reg   <= RST_WAYS_IN_USE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WRITE_THROUGH: write_through_reg <= cfg_wdata[0];
                CFG_OFFSET_BITS:   offset_bits_reg   <= cfg_wdata;
                CFG_INDEX_BITS:    index_bits_reg    <= cfg_wdata;
                CFG_WAYS_IN_USE:   ways_in_use_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Out-of-range register values are clamped into the legal geometry:
    // offset bits into 3 to 12, index bits to what the set store holds, and
    // the way count into 1 to MAX_WAYS.
    always_comb
    begin
        geom.write_through = write_through_reg;

        if (offset_bits_reg < 4'(OFFSET_MIN))
        begin
            geom.offset_bits = 4'(OFFSET_MIN);
        end
        else if (offset_bits_reg > 4'(OFFSET_MAX))
        begin
            geom.offset_bits = 4'(OFFSET_MAX);
        end
        else
        begin
            geom.offset_bits = offset_bits_reg;
        end

        if (index_bits_reg > 4'(IDX_MAX))
        begin
            geom.index_bits = 4'(IDX_MAX);
        end
        else
        begin
            geom.index_bits = index_bits_reg;
        end

        if (ways_in_use_reg == 4'd0)
        begin
            geom.ways = WAYS_W'(1);
        end
        else if ({1'b0, ways_in_use_reg} > WAYS_W'(MAX_WAYS))
        begin
            geom.ways = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            geom.ways = {1'b0, ways_in_use_reg};
        end
    end

    // The controller steps each item through load, lookup and update; the
    // next item may be accepted during the update step.
    salc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // The datapath holds one set per RAM row with tags, valid and dirty
    // flags and LRU ranks for all ways, and forms the result item.
    salc_dpath #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .request (request),
        .geom    (geom),
        .result  (result)
    );

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for set_assoc_lru_data_cache, the tag-only LRU cache model.
// It depends on salc_pkg and the RTL top level; it drives accesses, predicts each result
// and compares it with what the block reports.

module testbench;
    import salc_pkg::*;

    localparam int MAX_SETS      = 256;
    localparam int MAX_WAYS      = 8;
    localparam int LINES         = MAX_SETS * MAX_WAYS;
    // Cycles with neither an accepted item nor a result before the run is given up.
    localparam int STALL_LIMIT   = 2000;
    // Cycles waited after the last result of a phase has come back.
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 10;

    // One access in flight: the item, its predicted result and the cycle it was accepted.
    typedef struct {
        req_t        acc;
        rsp_t        rsp;
        int unsigned cyc;
    } pending_outcome_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    req_t                  request   = '0;
    logic                  done;
    rsp_t                  result;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_WRITE_THROUGH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    req_t             access_q[$];
    pending_outcome_t outcome_q[$];
    int               sender_idle_pct = 0;
    int unsigned      cycle_no        = 0;
    int               stall_count     = 0;
    int               fault_count     = 0;

    // Shadow copy of the configuration registers, as last written.
    logic       sh_write_through = RST_WRITE_THROUGH;
    logic [3:0] sh_offset_bits   = RST_OFFSET_BITS;
    logic [3:0] sh_index_bits    = RST_INDEX_BITS;
    logic [3:0] sh_ways_in_use   = RST_WAYS_IN_USE;

    // Shadow of the tag store. Entry (set, way) sits at set * MAX_WAYS + way.
    // Tags are only looked at while the line is valid.
    logic [TAG_W-1:0] line_tag   [LINES];
    bit               line_valid [LINES];
    bit               line_dirty [LINES];
    bit [2:0]         lru_rank   [LINES];

    set_assoc_lru_data_cache #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Geometry actually in effect: out-of-range register values are clamped.
    function automatic int eff_offset();
        if (sh_offset_bits < 3)
            return 3;
        if (sh_offset_bits > 12)
            return 12;
        return int'(sh_offset_bits);
    endfunction

    function automatic int eff_index();
        return (sh_index_bits > 8) ? 8 : int'(sh_index_bits);
    endfunction

    function automatic int eff_ways();
        if (sh_ways_in_use < 1)
            return 1;
        if (sh_ways_in_use > MAX_WAYS)
            return MAX_WAYS;
        return int'(sh_ways_in_use);
    endfunction

    // Make way w the most recently used one. Valid lines that were more recent age by
    // one, saturating at ways - 1. An invalid line counts as older than every other.
    function automatic void promote_way(int base, int nw, int w, bit was_valid);
        int r;
        int v;
        r = was_valid ? int'(lru_rank[base + w]) : nw;
        for (v = 0; v < nw; v++)
        begin
            if (v != w && line_valid[base + v] && int'(lru_rank[base + v]) < r &&
                int'(lru_rank[base + v]) + 1 < nw)
                lru_rank[base + v] = lru_rank[base + v] + 3'd1;
        end
        lru_rank[base + w] = 3'd0;
    endfunction

    // Look the access up in the shadow tag store, apply the hit or the allocation and
    // return the result that the block has to report for it.
    function automatic rsp_t lookup_and_update(req_t acc);
        int          ob;
        int          ib;
        int          nw;
        int          set_idx;
        int          base;
        int          w;
        int          hit_way;
        int          victim;
        int          e;
        bit          found;
        bit          was_valid;
        logic [63:0] a;
        logic [63:0] tg;
        logic [63:0] wb_line;
        rsp_t        res;
        ob      = eff_offset();
        ib      = eff_index();
        nw      = eff_ways();
        a       = 64'(acc.address);
        set_idx = int'((a >> ob) & ((64'd1 << ib) - 64'd1));
        tg      = a >> (ob + ib);
        base    = set_idx * MAX_WAYS;
        found   = 1'b0;
        hit_way = 0;
        res     = '0;

        for (w = 0; w < nw; w++)
        begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tg[TAG_W-1:0])
            begin
                found   = 1'b1;
                hit_way = w;
            end
        end

        res.hit       = found;
        res.set_index = set_idx[SET_OUT_W-1:0];
        res.tag_out   = tg[TAG_W-1:0];

        if (found)
        begin
            promote_way(base, nw, hit_way, 1'b1);
            if (acc.cmd == CMD_WRITE && !sh_write_through)
                line_dirty[base + hit_way] = 1'b1;
        end
        else if (acc.cmd == CMD_READ || !sh_write_through)
        begin
            // Lowest free way first; with the set full, the highest rank loses,
            // the lowest way winning a tie.
            victim = nw;
            for (w = 0; w < nw; w++)
            begin
                if (victim == nw && !line_valid[base + w])
                    victim = w;
            end
            if (victim == nw)
            begin
                victim = 0;
                for (w = 1; w < nw; w++)
                begin
                    if (lru_rank[base + w] > lru_rank[base + victim])
                        victim = w;
                end
            end
            e         = base + victim;
            was_valid = line_valid[e];
            // A dirty line left over from write-back mode is still written back
            // when it is evicted in write-through mode.
            if (was_valid && line_dirty[e])
            begin
                wb_line = (64'(line_tag[e]) << (ob + ib)) | (64'(set_idx) << ob);
                res.writeback         = 1'b1;
                res.writeback_address = wb_line[ADDR_WIDTH-1:0];
            end
            promote_way(base, nw, victim, was_valid);
            line_tag[e]   = tg[TAG_W-1:0];
            line_valid[e] = 1'b1;
            line_dirty[e] = (acc.cmd == CMD_WRITE);
        end
        // A write miss in write-through mode leaves the cache as it is.
        return res;
    endfunction

    // Driver. An item is accepted at an edge where start is high and busy is low; the
    // prediction is made right there, in acceptance order. A pending item that has not
    // been taken yet stays on the port; a free slot is filled unless the sender idles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                outcome_q.push_back('{acc: request, rsp: lookup_and_update(request),
                                      cyc: cycle_no});
            if (!start || !busy)
            begin
                if (access_q.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    start   <= 1'b1;
                    request <= access_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor. The block cannot be held off, so every strobe is checked at once against
    // the oldest access in flight. An access accepted at this very edge does not count
    // yet: its result cannot be due, and this keeps the check independent of whether
    // the driver or the monitor runs first.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0 || outcome_q[0].cyc == cycle_no)
            begin
                if (fault_count < REPORT_LIMIT)
                    $display("%0t: result with no access outstanding: hit=%0b wb=%0b wba=%h set=%0d tag=%h",
                             $realtime, result.hit, result.writeback,
                             result.writeback_address, result.set_index, result.tag_out);
                fault_count <= fault_count + 1;
            end
            else
            begin
                if (result.hit !== outcome_q[0].rsp.hit ||
                    result.writeback !== outcome_q[0].rsp.writeback ||
                    result.writeback_address !== outcome_q[0].rsp.writeback_address ||
                    result.set_index !== outcome_q[0].rsp.set_index ||
                    result.tag_out !== outcome_q[0].rsp.tag_out)
                begin
                    if (fault_count < REPORT_LIMIT)
                    begin
                        $display("%0t: %s %h: expected hit=%0b wb=%0b wba=%h set=%0d tag=%h",
                                 $realtime,
                                 outcome_q[0].acc.cmd == CMD_WRITE ? "write" : "read",
                                 outcome_q[0].acc.address, outcome_q[0].rsp.hit,
                                 outcome_q[0].rsp.writeback,
                                 outcome_q[0].rsp.writeback_address,
                                 outcome_q[0].rsp.set_index, outcome_q[0].rsp.tag_out);
                        $display("%0t:   got      hit=%0b wb=%0b wba=%h set=%0d tag=%h",
                                 $realtime, result.hit, result.writeback,
                                 result.writeback_address, result.set_index,
                                 result.tag_out);
                    end
                    fault_count <= fault_count + 1;
                end
                void'(outcome_q.pop_front());
            end
        end
    end

    // Watchdog: counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (!rst_n || (start && !busy) || done)
            stall_count <= 0;
        else if (stall_count >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
            $display("** set_assoc_lru_data_cache: FAILED **");
            $finish;
        end
        else
            stall_count <= stall_count + 1;
    end

    task automatic queue_access(input logic cmd, input logic [ADDR_WIDTH-1:0] addr);
        req_t it;
        it.cmd     = cmd;
        it.address = addr;
        access_q.push_back(it);
    endtask

    // Register write, only ever issued while the block is idle. The shadow copy is
    // updated at the edge that performs the write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WRITE_THROUGH: sh_write_through = data[0];
            CFG_OFFSET_BITS:   sh_offset_bits   = data;
            CFG_INDEX_BITS:    sh_index_bits    = data;
            CFG_WAYS_IN_USE:   sh_ways_in_use   = data;
            default:           ;
        endcase
    endtask

    // Wait until every queued item has been taken and every result has come back,
    // then let the pipeline settle.
    task automatic wait_drained();
        @(negedge clk);
        while (access_q.size() > 0 || start || outcome_q.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random phase under a given setting. Most accesses pick from a small pool of
    // sets and from two more tags than there are ways, so that hits, dirty lines and
    // evictions come often; the rest are fully random addresses.
    task automatic run_random_phase(input bit wt, input int ob_raw, input int ib_raw,
                                    input int ways_raw, input int idle, input int count);
        logic [63:0] set_pool [4];
        logic [63:0] tag_pool [10];
        logic [63:0] a;
        int          ob;
        int          ib;
        int          nw;
        int          k;
        // Upper bits of the write_through data are ignored by the block; fill them randomly.
        write_reg(CFG_WRITE_THROUGH, {3'($urandom_range(7)), wt});
        write_reg(CFG_OFFSET_BITS, 4'(ob_raw));
        write_reg(CFG_INDEX_BITS, 4'(ib_raw));
        write_reg(CFG_WAYS_IN_USE, 4'(ways_raw));
        ob = eff_offset();
        ib = eff_index();
        nw = eff_ways();
        for (k = 0; k < 4; k++)
            set_pool[k] = 64'($urandom) & ((64'd1 << ib) - 64'd1);
        for (k = 0; k < 10; k++)
            tag_pool[k] = 64'($urandom) & ((64'd1 << (ADDR_WIDTH - ob - ib)) - 64'd1);
        @(negedge clk);
        sender_idle_pct = idle;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(99) < 85)
                a = (tag_pool[$urandom_range(nw + 1)] << (ob + ib)) |
                    (set_pool[$urandom_range(3)] << ob) |
                    (64'($urandom) & ((64'd1 << ob) - 64'd1));
            else
                a = 64'($urandom);
            queue_access($urandom_range(1) ? CMD_WRITE : CMD_READ, a[ADDR_WIDTH-1:0]);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed accesses under the reset setting: write-back, 32-byte lines,
        // 16 sets, two ways. The set is address bits 8:5, the tag bits 31:9.
        @(negedge clk);
        sender_idle_pct = 11;
        queue_access(CMD_READ,  32'h0000_0000);  // cold miss, fills way 0
        queue_access(CMD_READ,  32'h0000_001F);  // hit at the highest offset
        queue_access(CMD_WRITE, 32'h0000_0004);  // write hit marks the line dirty
        queue_access(CMD_READ,  32'h0000_0200);  // same set, fills the free way
        queue_access(CMD_READ,  32'h0000_0000);  // hit, line 0 becomes most recent
        queue_access(CMD_READ,  32'h0000_0400);  // full set, clean line evicted
        queue_access(CMD_READ,  32'h0000_0600);  // dirty line 0 evicted and written back
        queue_access(CMD_WRITE, 32'hFFFF_FFFF);  // write miss allocates dirty
        queue_access(CMD_READ,  32'hFFFF_FFE0);  // hit on the top line
        queue_access(CMD_WRITE, 32'hFFFF_FDE0);  // second dirty line in the top set
        queue_access(CMD_READ,  32'h7FFF_FFE0);  // evicts the dirty top line
        queue_access(CMD_WRITE, 32'hAAAA_AAAA);
        queue_access(CMD_READ,  32'h5555_5555);
        queue_access(CMD_WRITE, 32'h5555_5555);
        wait_drained();

        // Write-through, with the unused data bits set as well.
        write_reg(CFG_WRITE_THROUGH, 4'hF);
        @(negedge clk);
        queue_access(CMD_WRITE, 32'h0000_1000);  // write miss leaves the cache alone
        queue_access(CMD_READ,  32'h0000_1000);  // still a miss, read allocates
        queue_access(CMD_READ,  32'h3FFF_FFE0);  // leftover dirty line still written back
        queue_access(CMD_WRITE, 32'h7FFF_FFE0);  // write hit does not mark dirty
        wait_drained();

        // Random phases. The stored lines survive every change of geometry. The first
        // three let the sender idle a little, the next three a lot, the last not at all.
        run_random_phase(1'b0, 3, 0, 1, 11, 92);    // smallest lines, one set, direct mapped
        run_random_phase(1'b0, 12, 8, 8, 11, 92);   // largest geometry
        run_random_phase(1'b1, 0, 15, 15, 11, 92);  // all fields clamped
        run_random_phase(1'b0, 4, 2, 4, 59, 92);
        run_random_phase(1'b1, 15, 1, 0, 59, 92);   // offset and ways clamped
        run_random_phase(1'b0, 6, 3, 3, 59, 92);
        run_random_phase(1'b0, 5, 4, 2, 0, 92);     // back to the reset setting
        run_random_phase(1'b1, 7, 5, 8, 0, 92);
        run_random_phase(1'b0, 0, 8, 15, 0, 92);

        if (fault_count == 0 && outcome_q.size() == 0)
            $display("** set_assoc_lru_data_cache: PASSED **");
        else
        begin
            $display("%0d mismatches, %0d results never seen", fault_count, outcome_q.size());
            $display("** set_assoc_lru_data_cache: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_ctrl.sv
rtl/salc_dpath.sv
rtl/set_assoc_lru_data_cache.sv
verif/testbench.sv
